// ----- rtl/vnsl_pkg.sv -----
// ----------------------------------------------------------------------------
// vnsl_pkg
// Shared types and constants of the Voronoi nearest-site labeler.
// ----------------------------------------------------------------------------
package vnsl_pkg;

	// Table and coordinate geometry
	localparam int MAX_SITES  = 256;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 4;
	localparam int SITE_W     = COORD_BITS + FRAC_BITS;
	localparam int IDX_W      = $clog2(MAX_SITES);
	localparam int CNT_W      = $clog2(MAX_SITES + 1);
	localparam int SQ_W       = 2 * SITE_W;
	localparam int DIST_W     = SQ_W + 1;

	// Configuration port
	localparam int CFG_W     = 9;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SITE_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SHADE_STEP = 1'b1;
	localparam logic [8:0] SITE_COUNT_RST = 9'd256;
	localparam logic [7:0] SHADE_STEP_RST = 8'd1;

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Input word
	typedef struct packed {
		logic        op;
		logic [7:0]  site_index;
		logic [15:0] site_x;
		logic [15:0] site_y;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [7:0] nearest_index;
		logic [7:0] shade;
	} out_word_t;

	// One table entry
	typedef struct packed {
		logic [SITE_W-1:0] x;
		logic [SITE_W-1:0] y;
	} site_t;

	// Tag that follows a site through the distance pipeline
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} tag_t;

	// Search sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

endpackage

// ----- rtl/voronoi_nearest_site_labeler_top.sv -----
// ----------------------------------------------------------------------------
// voronoi_nearest_site_labeler_top
// Loads sites into a table and labels each queried pixel with its nearest
// site index and a shade.
//
//   channel   direction  handshake            word
//   in        input      in_valid / in_stall  in_word_t (load or query)
//   out       output     out_valid/out_stall  out_word_t (one per query)
//   cfg       input      cfg_we               cfg_index, cfg_wdata
//
// A load is taken while idle. A query scans the sites in use: the table's
// single read port delivers one site per cycle into the distance pipeline,
// followed by its drain. The result waits in an output register, so the next
// word is taken while it is still unread; a search that finishes while that
// register is still full holds until it is read. Reset clears control state
// and the configuration registers; the site table is not cleared and is
// undefined until loaded. Input is stalled while a query runs.
// ----------------------------------------------------------------------------
module voronoi_nearest_site_labeler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  vnsl_pkg::in_word_t            in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output vnsl_pkg::out_word_t           out_word,
	input  logic                          cfg_we,
	input  logic [vnsl_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [vnsl_pkg::CFG_W-1:0]    cfg_wdata
);
	import vnsl_pkg::*;

	state_t            state_q, state_d;
	logic [8:0]        site_count_q;
	logic [7:0]        shade_step_q;
	logic [CNT_W-1:0]  cnt_sat;
	logic [CNT_W-1:0]  iss_q;
	logic [SITE_W-1:0] px_q, py_q;
	tag_t              rd_tag_s1;
	site_t             rd_site;
	tag_t              dist_tag;
	logic [DIST_W-1:0] sq_dist;
	logic              dist_busy;
	logic              pipe_empty;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DIST_W-1:0] best_d_q;
	logic              have_q;
	logic              in_acc, query_acc, load_we, load_ok;
	logic              issue, out_load;
	logic [15:0]       shade_prod;
	logic              out_valid_q;
	out_word_t         out_word_q;
	site_t             load_site;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q <= SITE_COUNT_RST;
			shade_step_q <= SHADE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SITE_COUNT: site_count_q <= cfg_wdata[8:0];
				REG_SHADE_STEP: shade_step_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Clamp the count to the table size
	assign cnt_sat = (CNT_W'(site_count_q) > CNT_W'(MAX_SITES)) ?
		CNT_W'(MAX_SITES) : CNT_W'(site_count_q);

	// Input handshake
	assign in_acc    = in_valid && !in_stall;
	assign query_acc = in_acc && (in_word.op == OP_QUERY);
	assign load_ok   = ({1'b0, in_word.site_index} < 9'(MAX_SITES));
	assign load_we   = in_acc && (in_word.op == OP_LOAD) && load_ok;
	assign load_site = '{x: in_word.site_x[SITE_W-1:0], y: in_word.site_y[SITE_W-1:0]};

	// Site table; loads happen only when idle, reads only while scanning
	vnsl_site_mem u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (in_word.site_index[IDX_W-1:0]),
		.wdata (load_site),
		.re    (issue),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (rd_site)
	);

	// Distance pipeline
	vnsl_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (rd_tag_s1),
		.site     (rd_site),
		.px       (px_q),
		.py       (py_q),
		.dist_tag (dist_tag),
		.sq_dist  (sq_dist),
		.busy     (dist_busy)
	);

	assign pipe_empty = !rd_tag_s1.vld && !dist_busy;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (query_acc) state_d = ST_SCAN;
			ST_SCAN:  if (!issue) state_d = ST_DRAIN;
			ST_DRAIN: if (pipe_empty) state_d = out_load ? ST_IDLE : ST_HOLD;
			ST_HOLD:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_SCAN:  issue = (iss_q < cnt_sat);
			ST_DRAIN: out_load = pipe_empty && (!out_valid_q || !out_stall);
			ST_HOLD:  out_load = !out_valid_q || !out_stall;
			default:  in_stall = 1'b1;
		endcase
	end

	// State, issue counter, read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_q     <= '0;
			rd_tag_s1 <= '0;
		end else begin
			state_q       <= state_d;
			rd_tag_s1.vld <= issue;
			rd_tag_s1.idx <= iss_q[IDX_W-1:0];
			if (query_acc) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	// Hold the pixel on the site grid
	always_ff @(posedge clk) begin
		if (query_acc) begin
			px_q <= {in_word.pixel_x[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
			py_q <= {in_word.pixel_y[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	// Track the best site; strict compare keeps the lower index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_idx_q <= '0;
		end else if (query_acc) begin
			have_q     <= 1'b0;
			best_idx_q <= '0;
		end else if (dist_tag.vld && (!have_q || sq_dist < best_d_q)) begin
			have_q     <= 1'b1;
			best_idx_q <= dist_tag.idx;
		end
	end

	always_ff @(posedge clk) begin
		if (dist_tag.vld && (!have_q || sq_dist < best_d_q)) begin
			best_d_q <= sq_dist;
		end
	end

	assign shade_prod = 16'(best_idx_q) * 16'(shade_step_q);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q.nearest_index <= 8'(best_idx_q);
			out_word_q.shade         <= shade_prod[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Reads stay inside the sites in use
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (iss_q < cnt_sat))
		else $error("site read beyond count");

	// A result is taken only after every distance has been compared
	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> pipe_empty)
		else $error("result loaded with distances in flight");

	// A query closes the input until it finishes
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> in_stall)
		else $error("input open during search");

	// Table write and read never share a cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |-> !issue)
		else $error("table write during scan");

	// The winning index is one of the searched sites
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cnt_sat != '0) |-> (CNT_W'(best_idx_q) < cnt_sat))
		else $error("nearest index beyond count");

endmodule

// ----- rtl/vnsl_site_mem.sv -----
// ----------------------------------------------------------------------------
// vnsl_site_mem
// Site table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vnsl_site_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [vnsl_pkg::IDX_W-1:0] waddr,
	input  vnsl_pkg::site_t            wdata,
	input  logic                       re,
	input  logic [vnsl_pkg::IDX_W-1:0] raddr,
	output vnsl_pkg::site_t            rdata
);
	import vnsl_pkg::*;

	site_t mem [MAX_SITES];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry into a register
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/vnsl_dist_unit.sv -----
// ----------------------------------------------------------------------------
// vnsl_dist_unit
// Three-stage squared distance pipeline: absolute difference, square, sum.
// ----------------------------------------------------------------------------
module vnsl_dist_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vnsl_pkg::tag_t              tag,
	input  vnsl_pkg::site_t             site,
	input  logic [vnsl_pkg::SITE_W-1:0] px,
	input  logic [vnsl_pkg::SITE_W-1:0] py,
	output vnsl_pkg::tag_t              dist_tag,
	output logic [vnsl_pkg::DIST_W-1:0] sq_dist,
	output logic                        busy
);
	import vnsl_pkg::*;

	tag_t              tag_s2, tag_s3, tag_s4;
	logic [SITE_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [DIST_W-1:0] dist_s4;

	// Advance the tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Absolute differences, squares, sum
	always_ff @(posedge clk) begin
		dx_s2   <= (px >= site.x) ? (px - site.x) : (site.x - px);
		dy_s2   <= (py >= site.y) ? (py - site.y) : (site.y - py);
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		dist_s4 <= DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
	end

	assign dist_tag = tag_s4;
	assign sq_dist  = dist_s4;
	assign busy     = tag_s2.vld | tag_s3.vld | tag_s4.vld;

endmodule

// ----- tb/vnsl_label_board_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vnsl_label_board_pkg
// Scoreboard for the Voronoi nearest-site labeler. It keeps its own copy of
// the site table and the registers, computes the label of every accepted
// query and checks the results in order.
// ----------------------------------------------------------------------------
package vnsl_label_board_pkg;

	import vnsl_pkg::*;

	class site_label_board;

		// Mirror of the block's state
		logic [SITE_W-1:0] x_tab [MAX_SITES];
		logic [SITE_W-1:0] y_tab [MAX_SITES];
		logic [8:0]        site_count;
		logic [7:0]        shade_step;

		// Labels still owed by the block, oldest first
		out_word_t label_q[$];

		int unsigned errors;
		int unsigned n_loads;
		int unsigned n_queries;
		int unsigned n_checked;
		int unsigned n_zero_count;
		int unsigned n_sat_count;

		function new();
			site_count = SITE_COUNT_RST;
			shade_step = SHADE_STEP_RST;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_SITE_COUNT) begin
				site_count = val[8:0];
			end else begin
				shade_step = val[7:0];
			end
		endfunction

		// Squared distance along one axis, in 1/256 square pixels
		function logic [33:0] axis_sq(logic [SITE_W-1:0] a, logic [SITE_W-1:0] b);
			logic [33:0] span;
			span = (a >= b) ? (a - b) : (b - a);
			return span * span;
		endfunction

		// Scan the sites in use; a strictly smaller distance wins
		function out_word_t nearest_label(logic [11:0] pix_x, logic [11:0] pix_y);
			logic [SITE_W-1:0] px;
			logic [SITE_W-1:0] py;
			logic [33:0]       sq_dist;
			logic [33:0]       best_dist;
			logic [7:0]        best;
			logic [15:0]       prod;
			int                n;
			out_word_t         res;
			px = {pix_x, 4'b0000};
			py = {pix_y, 4'b0000};
			n = (site_count > MAX_SITES) ? MAX_SITES : int'(site_count);
			best = '0;
			best_dist = '0;
			for (int i = 0; i < n; i++) begin
				sq_dist = axis_sq(px, x_tab[i]) + axis_sq(py, y_tab[i]);
				if (i == 0 || sq_dist < best_dist) begin
					best_dist = sq_dist;
					best = 8'(i);
				end
			end
			prod = best * shade_step;
			res.nearest_index = best;
			res.shade = prod[7:0];
			return res;
		endfunction

		// Apply an accepted word: store a site or queue the owed label
		function void note_word(in_word_t w);
			if (w.op == OP_LOAD) begin
				x_tab[w.site_index] = w.site_x;
				y_tab[w.site_index] = w.site_y;
				n_loads++;
			end else begin
				if (site_count == 0) n_zero_count++;
				if (site_count > MAX_SITES) n_sat_count++;
				label_q.push_back(nearest_label(w.pixel_x, w.pixel_y));
				n_queries++;
			end
		endfunction

		// Compare one delivered word with the oldest owed label
		function void check_label(out_word_t got);
			out_word_t want;
			if (label_q.size() == 0) begin
				$display("%0t: unexpected result index %0d shade %0d, no query pending",
					$time, got.nearest_index, got.shade);
				errors++;
				return;
			end
			want = label_q.pop_front();
			n_checked++;
			if (got.nearest_index !== want.nearest_index) begin
				$display("%0t: nearest_index mismatch, expected %0d actual %0d",
					$time, want.nearest_index, got.nearest_index);
				errors++;
			end
			if (got.shade !== want.shade) begin
				$display("%0t: shade mismatch, expected %0d actual %0d",
					$time, want.shade, got.shade);
				errors++;
			end
		endfunction

		// Count labels that never arrived
		function void close_out();
			while (label_q.size() != 0) begin
				out_word_t want;
				want = label_q.pop_front();
				$display("%0t: missing result, expected index %0d shade %0d",
					$time, want.nearest_index, want.shade);
				errors++;
			end
		endfunction

	endclass

endpackage

// ----- tb/voronoi_nearest_site_labeler_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voronoi_nearest_site_labeler_top_test
// Loads sites and queries pixels through the valid/stall channel, checking
// each label against a scoreboard. A short directed run covers extreme
// coordinates, zero count, ties and shade wrap; random phases then vary the
// site count (including values above the table size), the shade step, tie-rich
// placements, sender bursts and receiver stalls, with long output hold-offs.
// ----------------------------------------------------------------------------
module voronoi_nearest_site_labeler_top_test;

	import vnsl_pkg::*;
	import vnsl_label_board_pkg::*;

	localparam int WORD_TARGET = 1700;
	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_word_t             in_word;
	logic                 out_valid;
	logic                 out_stall;
	out_word_t            out_word;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	site_label_board board = new();

	// Sender pacing and receiver hold-off control
	int unsigned burst_left;
	bit          calm;
	bit          hold_req;
	int unsigned n_holds;
	int unsigned n_words;

	voronoi_nearest_site_labeler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#30_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, board.label_q.size());
		$display("FAIL");
		$finish;
	end

	// Check every delivered word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_label(out_word);
	end

	// Receiver: stall in changing modes, plus long hold-offs on request
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned cyc;
		out_stall = 1'b0;
		mode_left = 0;
		hold_left = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end
			@(negedge clk);
			mode_left--;
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				n_holds++;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((cyc % 5) < 2);
				endcase
			end
		end
	end

	function automatic in_word_t load_word(logic [7:0] idx, logic [15:0] sx, logic [15:0] sy);
		in_word_t w;
		w.op = OP_LOAD;
		w.site_index = idx;
		w.site_x = sx;
		w.site_y = sy;
		w.pixel_x = 12'($urandom_range(0, 4095));
		w.pixel_y = 12'($urandom_range(0, 4095));
		return w;
	endfunction

	function automatic in_word_t query_word(logic [11:0] pxl_x, logic [11:0] pxl_y);
		in_word_t w;
		w.op = OP_QUERY;
		w.site_index = 8'($urandom_range(0, 255));
		w.site_x = 16'($urandom_range(0, 65535));
		w.site_y = 16'($urandom_range(0, 65535));
		w.pixel_x = pxl_x;
		w.pixel_y = pxl_y;
		return w;
	endfunction

	// Site coordinate: on a small pixel grid when chasing ties, else anywhere
	function automatic logic [15:0] site_coord(bit tie_rich);
		if (tie_rich) return {8'd0, 4'($urandom_range(0, 15)), 4'b0000};
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [11:0] pixel_coord(bit tie_rich);
		if (tie_rich) return 12'($urandom_range(0, 15));
		return 12'($urandom_range(0, 4095));
	endfunction

	// Offer one word in bursts with random gaps; hold it until taken
	task automatic put(in_word_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = calm ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_word <= w;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		board.note_word(w);
		n_words++;
		@(negedge clk);
	endtask

	// Pause until every label has come back, then let a load finish
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (board.label_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
		@(negedge clk);
	endtask

	// Stimulus
	initial begin
		int unsigned phase;
		int unsigned len;
		int unsigned live;
		int unsigned guard;
		logic [8:0]  cnt;
		logic [7:0]  step;
		bit          tie_rich;
		bit          hold_phase;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SITE_COUNT;
		cfg_wdata = '0;
		arst_n = 1'b0;
		burst_left = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		n_holds = 0;
		n_words = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: one site, then zero count
		write_reg(REG_SITE_COUNT, 9'd1);
		write_reg(REG_SHADE_STEP, 9'd0);
		put(load_word(8'd0, 16'h0000, 16'h0000));
		put(query_word(12'd0, 12'd0));
		put(query_word(12'hFFF, 12'hFFF));
		drain();
		write_reg(REG_SITE_COUNT, 9'd0);
		put(query_word(12'd1234, 12'd77));
		put(query_word(12'hFFF, 12'd0));

		// Directed: far corners, a duplicate site and an equidistant pair
		drain();
		put(load_word(8'd1, 16'hFFFF, 16'hFFFF));
		put(load_word(8'd2, 16'hFFF0, 16'h0000));
		put(load_word(8'd3, 16'h0000, 16'h0000));
		put(load_word(8'd4, 16'h0020, 16'h0000));
		drain();
		write_reg(REG_SITE_COUNT, 9'd5);
		write_reg(REG_SHADE_STEP, 9'h1FF);
		put(query_word(12'd0, 12'd0));
		put(query_word(12'hFFF, 12'hFFF));
		put(query_word(12'hFFF, 12'd0));
		put(query_word(12'd1, 12'd0));
		put(query_word(12'd2, 12'd0));
		put(query_word(12'd0, 12'hFFF));

		// Fill the whole table so that any count may be searched
		drain();
		calm = 1'b1;
		for (int i = 0; i < MAX_SITES; i++)
			put(load_word(8'(i), site_coord(i[0]), site_coord(i[0])));

		// Random phases
		phase = 0;
		while (n_words < WORD_TARGET) begin
			drain();
			case (phase)
				0: begin cnt = 9'd511; step = 8'd255; end
				1: begin cnt = 9'd256; step = 8'd0; end
				2: begin cnt = 9'd3;   step = 8'd37; end
				default: begin
					case ($urandom_range(0, 15))
						0: cnt = 9'd0;
						1: cnt = 9'd256;
						2: cnt = 9'($urandom_range(257, 511));
						3: cnt = 9'($urandom_range(64, 255));
						default: cnt = 9'($urandom_range(1, 12));
					endcase
					step = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
						: 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_SITE_COUNT, cnt);
			write_reg(REG_SHADE_STEP, {1'($urandom_range(0, 1)), step});
			calm = ($urandom_range(0, 3) == 0);
			tie_rich = ($urandom_range(0, 2) == 0);
			hold_phase = (phase == 2) || ($urandom_range(0, 11) == 0);
			len = (cnt > 9'd64) ? $urandom_range(8, 24) : $urandom_range(40, 120);
			live = (cnt > MAX_SITES) ? MAX_SITES : cnt;
			if (hold_phase) hold_req = 1'b1;
			for (int k = 0; k < len; k++) begin
				if (!hold_phase && $urandom_range(0, 9) < 4) begin
					// Mostly rewrite sites in use so the search sees them
					put(load_word((live != 0 && $urandom_range(0, 1))
						? 8'($urandom_range(0, live - 1)) : 8'($urandom_range(0, 255)),
						site_coord(tie_rich), site_coord(tie_rich)));
				end else begin
					put(query_word(pixel_coord(tie_rich), pixel_coord(tie_rich)));
				end
			end
			phase++;
		end

		// Wind down
		in_valid <= 1'b0;
		guard = 0;
		while (board.label_q.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		board.close_out();
		$display("Covered %0d loads and %0d queries (%0d labels checked) over %0d phases.",
			board.n_loads, board.n_queries, board.n_checked, phase);
		$display("Zero-count queries %0d, over-size count queries %0d, long hold-offs %0d.",
			board.n_zero_count, board.n_sat_count, n_holds);
		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
